// File: rtl/shdb_pkg.sv
// shdb_pkg: shared types and constants of the sample history buffer
// no dependencies; imported by the channel interfaces and the top level

package shdb_pkg;

  localparam int unsigned DEF_CAPACITY = 64;

  localparam int unsigned PCT_W   = 14;
  localparam int unsigned CNT_W   = 7;
  localparam int unsigned NUM_W   = 32;
  localparam int unsigned AGE_W   = 22;
  localparam int unsigned IVL_W   = 16;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned DIV_W   = 7;

  localparam logic [PCT_W-1:0] PCT_MAX          = 14'd10000;
  localparam logic [IVL_W-1:0] INTERVAL_RESET   = 16'd60;
  localparam logic [CNT_W-1:0] MAX_POINTS_RESET = 7'd64;

  typedef enum logic {
    OP_ADD  = 1'b0,
    OP_DUMP = 1'b1
  } op_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_ADDED = 2'd0,
    KIND_POINT = 2'd1,
    KIND_EMPTY = 2'd2
  } kind_t;

  typedef enum logic {
    REG_INTERVAL   = 1'b0,
    REG_MAX_POINTS = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_READ,
    S_SEND
  } state_t;

endpackage

// File: rtl/shdb_item_if.sv
// shdb_item_if: input word channel of the sample history buffer
// depends on shdb_pkg for field widths

interface shdb_item_if
  import shdb_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic             operation;
  logic [PCT_W-1:0] sample_pct;

  modport source (output valid, output operation, output sample_pct, input ready);
  modport sink   (input valid, input operation, input sample_pct, output ready);
endinterface

// File: rtl/shdb_result_if.sv
// shdb_result_if: result word channel of the sample history buffer
// depends on shdb_pkg for field widths

interface shdb_result_if
  import shdb_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [AGE_W-1:0]  point_age;
  logic [PCT_W-1:0]  stored_pct;
  logic [NUM_W-1:0]  record_number;
  logic [CNT_W-1:0]  sample_count;
  logic [NUM_W-1:0]  newest_number;
  logic              last_of_run;

  modport source (output valid, output kind, output point_age, output stored_pct,
                  output record_number, output sample_count, output newest_number,
                  output last_of_run, input ready);
  modport sink   (input valid, input kind, input point_age, input stored_pct,
                  input record_number, input sample_count, input newest_number,
                  input last_of_run, output ready);
endinterface

// File: rtl/shdb_cfg_if.sv
// shdb_cfg_if: register write channel of the sample history buffer
// depends on shdb_pkg for field widths

interface shdb_cfg_if
  import shdb_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic             index;
  logic [IVL_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/sample_history_decimating_buffer.sv
// sample_history_decimating_buffer: top level of the sample history buffer
// depends on shdb_pkg, shdb_item_if, shdb_result_if and shdb_cfg_if

// Keeps the newest CAPACITY moisture samples in a circular store, each with a
// running 32-bit number. An add word saturates the sample to 0..10000, stores
// it and returns one word, which shows in the cycle after the add word is
// taken. A dump word returns the held history oldest first, thinned to
// stride = count / max_points when count exceeds max_points, with the newest
// sample appended when the stride misses it; an empty store gives one empty
// marker. A dump first runs a 7-step restoring divider, only when thinning,
// then a read/send sequencer that handles each emitted point as a store
// read with age multiply, then the output word, and that waits while the
// sink holds ready low. The input is not ready while a word is in work.
// Register writes are taken at any time and meant for idle periods.

module sample_history_decimating_buffer
  import shdb_pkg::*;
#(
  parameter int unsigned CAPACITY = DEF_CAPACITY
) (
  input  logic            clk,
  input  logic            rst,
  shdb_item_if.sink       item,
  shdb_result_if.source   result,
  shdb_cfg_if.sink        cfg
);

  localparam int unsigned SW = $clog2(CAPACITY);
  localparam logic [7:0]       CAP8 = 8'(CAPACITY);
  localparam logic [CNT_W-1:0] CAPC = CNT_W'(CAPACITY);
  localparam logic [SW-1:0]    LAST_SLOT = SW'(CAPACITY - 1);

  // sequencer
  state_t state, state_next;

  // history state
  logic [PCT_W-1:0] mem [CAPACITY];
  logic [SW-1:0]    write_slot;
  logic [CNT_W-1:0] held_count;
  logic [NUM_W-1:0] next_number;

  // registers
  logic [IVL_W-1:0] interval;
  logic [CNT_W-1:0] max_points;

  // dump walk
  logic [SW-1:0]    oldest;
  logic [CNT_W-1:0] pos;
  logic [CNT_W-1:0] stride;

  // stride divider
  logic [7:0]       div_rem;
  logic [DIV_W-1:0] div_dvd;
  logic [2:0]       div_cnt;

  // output word registers
  kind_t            kind_q;
  logic [AGE_W-1:0] age_q;
  logic [PCT_W-1:0] pct_q;
  logic [NUM_W-1:0] num_q;
  logic [CNT_W-1:0] cnt_q;
  logic [NUM_W-1:0] newest_q;
  logic             last_q;

  logic             in_fire, out_fire;
  logic [CNT_W-1:0] m_eff;
  logic [PCT_W-1:0] pct_sat;
  logic [7:0]       oldest_sum, slot_sum;
  logic [SW-1:0]    slot;
  logic [CNT_W-1:0] behind;
  logic [NUM_W-1:0] newest;
  logic [7:0]       div_shift;
  logic             div_ge;
  logic [7:0]       pos_adv;
  logic [CNT_W-1:0] pos_next;
  logic [CNT_W+IVL_W-1:0] age_prod;

  assign in_fire  = item.valid && item.ready;
  assign out_fire = result.valid && result.ready;

  // zero max_points acts as one
  assign m_eff   = (max_points == '0) ? CNT_W'(1) : max_points;
  assign pct_sat = (item.sample_pct > PCT_MAX) ? PCT_MAX : item.sample_pct;

  // oldest slot = write_slot - count, wrapped once
  always_comb begin
    oldest_sum = 8'(write_slot) + CAP8 - 8'(held_count);
    if (oldest_sum >= CAP8) begin
      oldest_sum = oldest_sum - CAP8;
    end
  end

  // slot of the current position
  always_comb begin
    slot_sum = 8'(oldest) + 8'(pos);
    if (slot_sum >= CAP8) begin
      slot_sum = slot_sum - CAP8;
    end
    slot = slot_sum[SW-1:0];
  end

  assign behind   = held_count - CNT_W'(1) - pos;
  assign newest   = next_number - NUM_W'(1);
  assign age_prod = behind * interval;

  // one restoring step per cycle
  assign div_shift = {div_rem[6:0], div_dvd[DIV_W-1]};
  assign div_ge    = (div_shift >= 8'(m_eff));

  // next position; falls back to the newest sample when the stride overshoots
  assign pos_adv  = 8'(pos) + 8'(stride);
  assign pos_next = (pos_adv >= 8'(held_count)) ? (held_count - CNT_W'(1))
                                                : pos_adv[CNT_W-1:0];

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_fire) begin
          if (item.operation == OP_DUMP && held_count != '0) begin
            state_next = (held_count > m_eff) ? S_DIV : S_READ;
          end else begin
            state_next = S_SEND;
          end
        end
      end
      S_DIV: begin
        if (div_cnt == 3'(DIV_W - 1)) begin
          state_next = S_READ;
        end
      end
      S_READ: state_next = S_SEND;
      S_SEND: begin
        if (out_fire) begin
          state_next = last_q ? S_IDLE : S_READ;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    item.ready   = 1'b0;
    result.valid = 1'b0;
    case (state)
      S_IDLE:  item.ready   = 1'b1;
      S_SEND:  result.valid = 1'b1;
      default: begin
        item.ready   = 1'b0;
        result.valid = 1'b0;
      end
    endcase
  end

  assign cfg.ready = 1'b1;

  assign result.kind          = kind_q;
  assign result.point_age     = age_q;
  assign result.stored_pct    = pct_q;
  assign result.record_number = num_q;
  assign result.sample_count  = cnt_q;
  assign result.newest_number = newest_q;
  assign result.last_of_run   = last_q;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      write_slot  <= '0;
      held_count  <= '0;
      next_number <= '0;
      interval    <= INTERVAL_RESET;
      max_points  <= MAX_POINTS_RESET;
    end else begin
      state <= state_next;
      if (in_fire && item.operation == OP_ADD) begin
        write_slot  <= (write_slot == LAST_SLOT) ? '0 : write_slot + SW'(1);
        held_count  <= (held_count < CAPC) ? held_count + CNT_W'(1) : held_count;
        next_number <= next_number + NUM_W'(1);
      end
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_INTERVAL:   interval   <= cfg.data;
          REG_MAX_POINTS: max_points <= cfg.data[CNT_W-1:0];
          default:        interval   <= interval;
        endcase
      end
    end
  end

  // store and store read port
  always_ff @(posedge clk) begin
    if (in_fire && item.operation == OP_ADD) begin
      mem[write_slot] <= pct_sat;
    end
    if (state == S_IDLE && in_fire) begin
      pct_q <= (item.operation == OP_ADD) ? pct_sat : '0;
    end else if (state == S_READ) begin
      pct_q <= mem[slot];
    end
  end

  // dump walk, divider and output word
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_fire) begin
          oldest  <= oldest_sum[SW-1:0];
          pos     <= '0;
          stride  <= CNT_W'(1);
          div_rem <= '0;
          div_dvd <= held_count;
          div_cnt <= '0;
          last_q  <= 1'b1;
          age_q   <= '0;
          if (item.operation == OP_ADD) begin
            kind_q   <= KIND_ADDED;
            num_q    <= next_number;
            newest_q <= next_number;
            cnt_q    <= (held_count < CAPC) ? held_count + CNT_W'(1) : held_count;
          end else begin
            kind_q   <= KIND_EMPTY;
            num_q    <= '0;
            newest_q <= '0;
            cnt_q    <= '0;
          end
        end
      end
      S_DIV: begin
        div_rem <= div_ge ? (div_shift - 8'(m_eff)) : div_shift;
        div_dvd <= {div_dvd[DIV_W-2:0], 1'b0};
        stride  <= {stride[CNT_W-2:0], div_ge};
        div_cnt <= div_cnt + 3'd1;
        if (div_cnt == '0) begin
          // first step clears the seed of one
          stride <= {{(CNT_W-1){1'b0}}, div_ge};
        end
      end
      S_READ: begin
        kind_q   <= KIND_POINT;
        age_q    <= age_prod[AGE_W-1:0];
        num_q    <= newest - NUM_W'(behind);
        newest_q <= newest;
        cnt_q    <= held_count;
        last_q   <= (pos == held_count - CNT_W'(1));
      end
      S_SEND: begin
        if (out_fire && !last_q) begin
          pos <= pos_next;
        end
      end
      default: pos <= pos;
    endcase
  end

endmodule
